[src/sncs_pkg.sv]
// shared types and constants for the spi nor flash command sequencer
package sncs_pkg;

  localparam int PageBytesDef   = 256;
  localparam int SectorBytesDef = 4096;

  typedef enum logic [1:0] {
    ACT_REQ  = 2'd0,
    ACT_WBYTE = 2'd1,
    ACT_DONE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SECT   = 3'd2,
    OP_BLOCK  = 3'd3,
    OP_CHIP   = 3'd4,
    OP_ID     = 3'd5,
    OP_WR_ERA = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    K_XFER  = 3'd0,
    K_CSREL = 3'd1,
    K_REQWR = 3'd2,
    K_RDBYTE = 3'd3,
    K_IDVAL = 3'd4,
    K_DONE  = 3'd5
  } kind_t;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b0000000001,
    PH_WREN      = 10'b0000000010,
    PH_POLL_CMD  = 10'b0000000100,
    PH_POLL_READ = 10'b0000001000,
    PH_CMD       = 10'b0000010000,
    PH_WAIT_WR   = 10'b0000100000,
    PH_DATA      = 10'b0001000000,
    PH_READ      = 10'b0010000000,
    PH_ID        = 10'b0100000000,
    PH_WRDI      = 10'b1000000000
  } phase_t;

  localparam logic [1:0] POLL_WEL_SET = 2'd0;
  localparam logic [1:0] POLL_WEL_CLR = 2'd1;
  localparam logic [1:0] POLL_BUSY    = 2'd2;

  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_RDID  = 8'h90;
  localparam logic [7:0] CMD_BE    = 8'hD8;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_CE    = 8'hC7;
  localparam logic [7:0] CMD_DUMMY = 8'hA5;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRDI  = 8'h04;
  localparam logic [7:0] SR_BUSY   = 8'h01;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic        frame_start;
    logic [15:0] data_value;
  } res_t;

endpackage

[src/spi_nor_flash_command_sequencer.sv]
// top level: spi nor flash command sequencer with result queue
// output: results of an input are registered and appear in the cycle after its transfer
// throughput: one input per cycle when each input causes one result and the output is not
// stalled; an input causing more than one result holds the input side while they drain
// reset: rst_n synchronous active low, sequencer idle, queue empty
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES   = sncs_pkg::PageBytesDef,
  parameter int SECTOR_BYTES = sncs_pkg::SectorBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_op,
  input  logic [23:0] in_address,
  input  logic [24:0] in_length,
  input  logic [7:0]  in_wr_byte,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_start,
  output logic [15:0] out_data_value,
  output logic        out_last
);
  import sncs_pkg::*;

  localparam int CW = $clog2(PAGE_BYTES + 1);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam int SW = $clog2(SECTOR_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [24:0] tot_r, tot_nxt;
  logic [CW-1:0] chk_r, chk_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [1:0]  poll_r, poll_nxt;
  logic [7:0]  idh_r, idh_nxt;

  // result buffer: up to three pending results
  res_t       buf_r [3];
  logic [1:0] cnt_r, head_r;
  logic       lastmark_r [3];

  res_t       res [3];
  logic [1:0] nres;

  logic accept, pop;
  // take a new input when the buffer is empty or its final result leaves now
  assign in_stall = !((cnt_r == 2'd0) || (cnt_r == 2'd1 && !out_stall));
  assign accept   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop      = out_valid && !out_stall;

  // sequencer next state and results
  always_comb begin
    logic [24:0] room;
    logic [24:0] tot_d;
    logic        ok;
    logic [23:0] a;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    tot_nxt   = tot_r;
    chk_nxt   = chk_r;
    fidx_nxt  = fidx_r;
    poll_nxt  = poll_r;
    idh_nxt   = idh_r;
    nres      = 2'd0;
    ok        = 1'b0;
    a         = 24'd0;
    tot_d     = 25'd0;
    room      = 25'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (accept) begin
      case (in_action)
        ACT_REQ: begin
          if (phase_r == PH_IDLE && in_op <= OP_ID) begin
            op_nxt   = in_op;
            addr_nxt = in_address;
            tot_nxt  = in_length;
            fidx_nxt = 3'd0;
            nres     = 2'd1;
            res[0]   = '{K_XFER, CMD_WREN, 1'b1, 16'd0};
            if (in_op == OP_WRITE) begin
              room = 25'(PAGE_BYTES) - 25'(in_address[PW-1:0]);
              chk_nxt = CW'((in_length < room) ? in_length : room);
              op_nxt  = (in_address[SW-1:0] == '0) ? OP_WR_ERA : OP_WRITE;
              phase_nxt = PH_WREN;
            end else if (in_op == OP_READ || in_op == OP_ID) begin
              phase_nxt = PH_CMD;
              res[0].tx_byte = (in_op == OP_READ) ? CMD_READ : CMD_RDID;
            end else begin
              phase_nxt = PH_WREN;
            end
          end
        end
        ACT_WBYTE: begin
          if (phase_r == PH_WAIT_WR) begin
            phase_nxt = PH_DATA;
            nres   = 2'd1;
            res[0] = '{K_XFER, in_wr_byte, 1'b0, 16'd0};
          end
        end
        ACT_DONE: begin
          case (phase_r)
            PH_WREN, PH_WRDI: begin
              nres = 2'd2;
              res[0] = '{K_CSREL, 8'd0, 1'b0, 16'd0};
              res[1] = '{K_XFER, CMD_RDSR, 1'b1, 16'd0};
              poll_nxt = (phase_r == PH_WREN) ? POLL_WEL_SET : POLL_WEL_CLR;
              phase_nxt = PH_POLL_CMD;
            end
            PH_POLL_CMD: begin
              phase_nxt = PH_POLL_READ;
              nres = 2'd1;
              res[0] = '{K_XFER, CMD_DUMMY, 1'b0, 16'd0};
            end
            PH_POLL_READ: begin
              if (poll_r == POLL_WEL_SET) ok = in_rx_byte[1];
              else if (poll_r == POLL_WEL_CLR) ok = !in_rx_byte[1];
              else ok = !(|(in_rx_byte & SR_BUSY));
              if (!ok) begin
                nres = 2'd1;
                res[0] = '{K_XFER, CMD_DUMMY, 1'b0, 16'd0};
              end else begin
                nres = 2'd2;
                res[0] = '{K_CSREL, 8'd0, 1'b0, 16'd0};
                if (poll_r == POLL_WEL_SET) begin
                  // main command frame
                  fidx_nxt = 3'd0;
                  phase_nxt = PH_CMD;
                  case (op_r)
                    OP_WRITE: res[1] = '{K_XFER, CMD_PP, 1'b1, 16'd0};
                    OP_BLOCK: res[1] = '{K_XFER, CMD_BE, 1'b1, 16'd0};
                    OP_CHIP:  res[1] = '{K_XFER, CMD_CE, 1'b1, 16'd0};
                    default:  res[1] = '{K_XFER, CMD_SE, 1'b1, 16'd0};
                  endcase
                end else if (poll_r == POLL_WEL_CLR) begin
                  poll_nxt = POLL_BUSY;
                  phase_nxt = PH_POLL_CMD;
                  res[1] = '{K_XFER, CMD_RDSR, 1'b1, 16'd0};
                end else if (op_r == OP_WR_ERA) begin
                  op_nxt = OP_WRITE;
                  phase_nxt = PH_WREN;
                  res[1] = '{K_XFER, CMD_WREN, 1'b1, 16'd0};
                end else if (op_r == OP_WRITE && tot_r != '0) begin
                  // next chunk
                  room = 25'(PAGE_BYTES) - 25'(addr_r[PW-1:0]);
                  chk_nxt = CW'((tot_r < room) ? tot_r : room);
                  op_nxt  = (addr_r[SW-1:0] == '0) ? OP_WR_ERA : OP_WRITE;
                  phase_nxt = PH_WREN;
                  res[1] = '{K_XFER, CMD_WREN, 1'b1, 16'd0};
                end else begin
                  phase_nxt = PH_IDLE;
                  res[1] = '{K_DONE, 8'd0, 1'b0, 16'd0};
                end
              end
            end
            PH_CMD, PH_DATA: begin
              if (phase_r == PH_CMD && op_r != OP_CHIP && fidx_r < 3'd3) begin
                fidx_nxt = fidx_r + 3'd1;
                a = (op_r == OP_ID) ? 24'd0 : addr_r;
                nres = 2'd1;
                res[0] = '{K_XFER, 8'd0, 1'b0, 16'd0};
                case (fidx_r)
                  3'd0:    res[0].tx_byte = a[23:16];
                  3'd1:    res[0].tx_byte = a[15:8];
                  default: res[0].tx_byte = a[7:0];
                endcase
              end else begin
                if (phase_r == PH_DATA) begin
                  chk_nxt  = chk_r - CW'(1);
                  tot_nxt  = tot_r - 25'd1;
                  addr_nxt = addr_r + 24'd1;
                end
                // end of header or data byte
                case (op_r)
                  OP_READ: begin
                    if (tot_r != '0) begin
                      phase_nxt = PH_READ;
                      nres = 2'd1;
                      res[0] = '{K_XFER, CMD_DUMMY, 1'b0, 16'd0};
                    end else begin
                      phase_nxt = PH_IDLE;
                      nres = 2'd2;
                      res[0] = '{K_CSREL, 8'd0, 1'b0, 16'd0};
                      res[1] = '{K_DONE, 8'd0, 1'b0, 16'd0};
                    end
                  end
                  OP_ID: begin
                    fidx_nxt = 3'd0;
                    phase_nxt = PH_ID;
                    nres = 2'd1;
                    res[0] = '{K_XFER, CMD_DUMMY, 1'b0, 16'd0};
                  end
                  default: begin
                    if (op_r == OP_WRITE && chk_nxt != '0) begin
                      phase_nxt = PH_WAIT_WR;
                      nres = 2'd1;
                      res[0] = '{K_REQWR, 8'd0, 1'b0, 16'd0};
                    end else begin
                      phase_nxt = PH_WRDI;
                      nres = 2'd2;
                      res[0] = '{K_CSREL, 8'd0, 1'b0, 16'd0};
                      res[1] = '{K_XFER, CMD_WRDI, 1'b1, 16'd0};
                    end
                  end
                endcase
              end
            end
            PH_READ: begin
              tot_d = tot_r - 25'd1;
              tot_nxt = tot_d;
              res[0] = '{K_RDBYTE, 8'd0, 1'b0, {8'd0, in_rx_byte}};
              if (tot_d != '0) begin
                nres = 2'd2;
                res[1] = '{K_XFER, CMD_DUMMY, 1'b0, 16'd0};
              end else begin
                phase_nxt = PH_IDLE;
                nres = 2'd3;
                res[1] = '{K_CSREL, 8'd0, 1'b0, 16'd0};
                res[2] = '{K_DONE, 8'd0, 1'b0, 16'd0};
              end
            end
            PH_ID: begin
              if (fidx_r == 3'd0) begin
                idh_nxt = in_rx_byte;
                fidx_nxt = 3'd1;
                nres = 2'd1;
                res[0] = '{K_XFER, CMD_DUMMY, 1'b0, 16'd0};
              end else begin
                phase_nxt = PH_IDLE;
                nres = 2'd3;
                res[0] = '{K_IDVAL, 8'd0, 1'b0, {idh_r, in_rx_byte}};
                res[1] = '{K_CSREL, 8'd0, 1'b0, 16'd0};
                res[2] = '{K_DONE, 8'd0, 1'b0, 16'd0};
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= '0;
      addr_r  <= '0;
      tot_r   <= '0;
      chk_r   <= '0;
      fidx_r  <= '0;
      poll_r  <= '0;
      idh_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      tot_r   <= tot_nxt;
      chk_r   <= chk_nxt;
      fidx_r  <= fidx_nxt;
      poll_r  <= poll_nxt;
      idh_r   <= idh_nxt;
    end
  end

  // result buffer: loaded when empty or as its final result leaves, drained one per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else if (accept) begin
      cnt_r  <= nres;
      head_r <= '0;
    end else if (pop) begin
      cnt_r  <= cnt_r - 2'd1;
      head_r <= head_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        buf_r[i]      <= res[i];
        lastmark_r[i] <= (2'(i) == nres - 2'd1);
      end
    end
  end

  always_comb begin
    res_t cur;
    cur = buf_r[0];
    case (head_r)
      2'd1:    cur = buf_r[1];
      2'd2:    cur = buf_r[2];
      default: cur = buf_r[0];
    endcase
    out_kind        = cur.kind;
    out_tx_byte     = cur.tx_byte;
    out_frame_start = cur.frame_start;
    out_data_value  = cur.data_value;
    out_last        = (head_r == 2'd1) ? lastmark_r[1] :
                      (head_r == 2'd2) ? lastmark_r[2] : lastmark_r[0];
  end

`ifndef ASSERT_OFF
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && accept) |-> (cnt_r == 2'd1 && pop))
    else $error("input taken while results pending");
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r == 2'd1) |-> out_last) else $error("final result lacks last");
  a_last_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r != 2'd1) |-> !out_last) else $error("early last");
  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chk_r <= CW'(PAGE_BYTES)) else $error("chunk count exceeds page");
`endif
endmodule
